[sv/vma_pkg.sv]
// ----------------------------------------------------------------------------
// vma_pkg
// shared widths, angle constants, the arctangent table and the pipeline types
// of the vector magnitude and angle unit
// ----------------------------------------------------------------------------
package vma_pkg;

	localparam int COORD_WIDTH_DEF   = 16;
	localparam int CORDIC_STAGES_DEF = 18;

	// square root: 42-bit radicand, one result bit per step
	localparam int SQRT_STEPS = 21;
	localparam int SQ_W       = 42;

	// rotation datapath and angle accumulator
	localparam int CW         = 64;
	localparam int CORDIC_TOP = 60;
	localparam int ZW         = 25;
	localparam int ANG_W      = 25;

	localparam int LEN_W       = 20;
	localparam int ANGLE_W     = 17;
	localparam int OUT_TDATA_W = 40;

	localparam logic [LEN_W-1:0]   LEN_MAX      = 20'hFFFFF;
	localparam logic [ANG_W-1:0]   DEG90_Q16    = 25'd5898240;
	localparam logic [ANG_W-1:0]   DEG180_Q16   = 25'd11796480;
	localparam logic [ANG_W-1:0]   DEG270_Q16   = 25'd17694720;
	localparam logic [ANG_W-1:0]   DEG360_Q16   = 25'd23592960;
	localparam logic [ANGLE_W-1:0] FULL_TURN_Q8 = 17'd92160;

	typedef struct packed {
		logic xneg;
		logic yneg;
		logic ax_zero;
		logic ay_zero;
		logic sat;
	} vma_flags_t;

	typedef struct packed {
		logic               zero_error;
		logic [ANGLE_W-1:0] angle_q8;
		logic [LEN_W-1:0]   length_q4;
	} vma_result_t;

	// atan(2^-i) in 1/65536 degree
	function automatic logic [21:0] atan_q16(input int unsigned idx);
		logic [21:0] val;
		case (idx)
			0:       val = 22'd2949120;
			1:       val = 22'd1740967;
			2:       val = 22'd919879;
			3:       val = 22'd466945;
			4:       val = 22'd234379;
			5:       val = 22'd117304;
			6:       val = 22'd58666;
			7:       val = 22'd29335;
			8:       val = 22'd14668;
			9:       val = 22'd7334;
			10:      val = 22'd3667;
			11:      val = 22'd1833;
			12:      val = 22'd917;
			13:      val = 22'd458;
			14:      val = 22'd229;
			15:      val = 22'd115;
			16:      val = 22'd57;
			17:      val = 22'd29;
			18:      val = 22'd14;
			19:      val = 22'd7;
			20:      val = 22'd4;
			21:      val = 22'd2;
			22:      val = 22'd1;
			default: val = 22'd0;
		endcase
		return val;
	endfunction

endpackage

[sv/vma_isqrt_stage.sv]
// ----------------------------------------------------------------------------
// vma_isqrt_stage
// one registered step of the digit-by-digit integer square root
// ----------------------------------------------------------------------------
module vma_isqrt_stage #(
	parameter int STEP = 0
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [vma_pkg::SQ_W-1:0] rem_in,
	input  logic [vma_pkg::SQ_W-1:0] root_in,
	output logic [vma_pkg::SQ_W-1:0] rem_out,
	output logic [vma_pkg::SQ_W-1:0] root_out
);
	import vma_pkg::*;

	localparam logic [SQ_W-1:0] TRIAL_BIT = SQ_W'(1) << (SQ_W - 2 - 2 * STEP);

	logic [SQ_W:0]   trial;
	logic [SQ_W-1:0] rem_s1;
	logic [SQ_W-1:0] root_s1;

	assign trial = {1'b0, root_in} + {1'b0, TRIAL_BIT};

	always_ff @(posedge clk) begin
		if (en) begin
			if ({1'b0, rem_in} >= trial) begin
				rem_s1  <= rem_in - trial[SQ_W-1:0];
				root_s1 <= (root_in >> 1) + TRIAL_BIT;
			end else begin
				rem_s1  <= rem_in;
				root_s1 <= root_in >> 1;
			end
		end
	end

	assign rem_out  = rem_s1;
	assign root_out = root_s1;

endmodule

[sv/vma_cordic_stage.sv]
// ----------------------------------------------------------------------------
// vma_cordic_stage
// one registered vectoring micro-rotation, driving y toward zero
// ----------------------------------------------------------------------------
module vma_cordic_stage #(
	parameter int IDX = 0
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [vma_pkg::CW-1:0] a_in,
	input  logic signed [vma_pkg::CW-1:0] b_in,
	input  logic signed [vma_pkg::ZW-1:0] z_in,
	output logic signed [vma_pkg::CW-1:0] a_out,
	output logic signed [vma_pkg::CW-1:0] b_out,
	output logic signed [vma_pkg::ZW-1:0] z_out
);
	import vma_pkg::*;

	localparam logic signed [ZW-1:0] ATAN_STEP = ZW'(atan_q16(IDX));

	logic signed [CW-1:0] a_s1;
	logic signed [CW-1:0] b_s1;
	logic signed [ZW-1:0] z_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!b_in[CW-1]) begin
				a_s1 <= a_in + (b_in >>> IDX);
				b_s1 <= b_in - (a_in >>> IDX);
				z_s1 <= z_in + ATAN_STEP;
			end else begin
				a_s1 <= a_in - (b_in >>> IDX);
				b_s1 <= b_in + (a_in >>> IDX);
				z_s1 <= z_in - ATAN_STEP;
			end
		end
	end

	assign a_out = a_s1;
	assign b_out = b_s1;
	assign z_out = z_s1;

endmodule

[sv/vector_magnitude_and_angle_unit.sv]
// ----------------------------------------------------------------------------
// vector_magnitude_and_angle_unit
// rectangular to polar conversion: length and screen-convention angle
// ----------------------------------------------------------------------------
// s_* takes one vector per word: coord_x and coord_y, two's complement.
// m_* returns one word per vector: length_q4 (length in 1/16, rounded),
// angle_q8 (atan2(-y, x) in 1/256 degree, 0 up to below 360) and, in tuser,
// zero_error, set for the zero vector, which then has length and angle 0.
// One vector enters per cycle while s_tready is high. The pipeline holds
// registers for absolute value, for the squares and for their sum, then the
// square root steps and the CORDIC rotations side by side, one step per
// stage, a stage folding into the quadrant and an output register.
// When the receiver stalls, the output word holds and a skid register takes
// one more finished word; only then the whole pipeline freezes and s_tready
// drops. Nothing is lost or repeated. Reset empties the pipeline; no
// clearing time is needed afterward.
// ----------------------------------------------------------------------------
module vector_magnitude_and_angle_unit #(
	parameter int COORD_WIDTH   = vma_pkg::COORD_WIDTH_DEF,
	parameter int CORDIC_STAGES = vma_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// coord_x, coord_y, zero fill
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]      s_tdata,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// length_q4, angle_q8, zero fill
	output logic [vma_pkg::OUT_TDATA_W-1:0]         m_tdata,
	// zero_error
	output logic                                    m_tuser
);
	import vma_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int N   = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
	localparam int NV  = N + 4;
	localparam int SHL = CORDIC_TOP - W;

	logic            en;
	logic [NV-1:0]   v_q;

	logic signed [W-1:0] in_x;
	logic signed [W-1:0] in_y;

	logic [W-1:0]   ax_s1, ay_s1;
	vma_flags_t     fl_s1;
	logic [W-1:0]   ax_s2, ay_s2;
	logic [2*W-1:0] axx_s2, ayy_s2;
	vma_flags_t     fl_s2;
	logic [W-1:0]   ax_s3, ay_s3;
	logic [SQ_W-1:0] sq_s3;
	vma_flags_t     fl_s3;
	logic [CW-1:0]  sum64;

	logic [SQ_W-1:0]      rv_sk [N+1];
	logic [SQ_W-1:0]      rr_sk [N+1];
	logic signed [CW-1:0] ca_sk [N+1];
	logic signed [CW-1:0] cb_sk [N+1];
	logic signed [ZW-1:0] cz_sk [N+1];
	vma_flags_t           fl_sk [N+1];

	logic [LEN_W-1:0] len_sf;
	logic [ANG_W-1:0] ang_sf;
	vma_flags_t       fl_sf;

	logic [SQ_W-1:0] root_end, rem_end;
	logic [21:0]     len_pre;
	logic [LEN_W-1:0] len_nxt;
	logic signed [ZW-1:0] z_end;
	logic [ANG_W-1:0] theta;
	logic [ANG_W-1:0] ang_nxt;
	logic [17:0]      ang_rnd;
	logic [ANGLE_W-1:0] ang_fin;
	vma_result_t      res_nxt;

	vma_result_t out_res_q, skid_res_q;
	logic        out_v_q, skid_v_q;
	logic        out_free;

	assign en       = !skid_v_q;
	assign s_tready = en;
	assign in_x     = s_tdata[W-1:0];
	assign in_y     = s_tdata[2*W-1:W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[NV-2:0], s_tvalid};
		end
	end

	// absolute values, squares, sum
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= in_x[W-1] ? W'(-in_x) : W'(in_x);
			ay_s1 <= in_y[W-1] ? W'(-in_y) : W'(in_y);
			fl_s1 <= '{xneg: in_x[W-1], yneg: in_y[W-1], ax_zero: (in_x == '0),
				ay_zero: (in_y == '0), sat: 1'b0};

			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			axx_s2 <= (2*W)'(ax_s1) * (2*W)'(ax_s1);
			ayy_s2 <= (2*W)'(ay_s1) * (2*W)'(ay_s1);
			fl_s2  <= fl_s1;

			ax_s3     <= ax_s2;
			ay_s3     <= ay_s2;
			sq_s3     <= {sum64[33:0], 8'd0};
			fl_s3     <= '{xneg: fl_s2.xneg, yneg: fl_s2.yneg, ax_zero: fl_s2.ax_zero,
				ay_zero: fl_s2.ay_zero, sat: (sum64[CW-1:34] != '0)};
		end
	end

	assign sum64 = CW'(axx_s2) + CW'(ayy_s2);

	assign rv_sk[0] = sq_s3;
	assign rr_sk[0] = '0;
	assign ca_sk[0] = CW'(ax_s3) << SHL;
	assign cb_sk[0] = CW'(ay_s3) << SHL;
	assign cz_sk[0] = '0;
	assign fl_sk[0] = fl_s3;

	// square root steps and rotations, side by side
	for (genvar k = 0; k < N; k++) begin : g_core
		if (k < SQRT_STEPS) begin : g_sqrt
			vma_isqrt_stage #(.STEP(k)) u_sqrt (
				.clk      (clk),
				.en       (en),
				.rem_in   (rv_sk[k]),
				.root_in  (rr_sk[k]),
				.rem_out  (rv_sk[k+1]),
				.root_out (rr_sk[k+1])
			);
		end else begin : g_sqrt_pass
			logic [SQ_W-1:0] rv_s1, rr_s1;
			always_ff @(posedge clk) begin
				if (en) begin
					rv_s1 <= rv_sk[k];
					rr_s1 <= rr_sk[k];
				end
			end
			assign rv_sk[k+1] = rv_s1;
			assign rr_sk[k+1] = rr_s1;
		end

		if (k < CORDIC_STAGES) begin : g_rot
			vma_cordic_stage #(.IDX(k)) u_rot (
				.clk   (clk),
				.en    (en),
				.a_in  (ca_sk[k]),
				.b_in  (cb_sk[k]),
				.z_in  (cz_sk[k]),
				.a_out (ca_sk[k+1]),
				.b_out (cb_sk[k+1]),
				.z_out (cz_sk[k+1])
			);
		end else begin : g_rot_pass
			logic signed [CW-1:0] ca_s1, cb_s1;
			logic signed [ZW-1:0] cz_s1;
			always_ff @(posedge clk) begin
				if (en) begin
					ca_s1 <= ca_sk[k];
					cb_s1 <= cb_sk[k];
					cz_s1 <= cz_sk[k];
				end
			end
			assign ca_sk[k+1] = ca_s1;
			assign cb_sk[k+1] = cb_s1;
			assign cz_sk[k+1] = cz_s1;
		end

		vma_flags_t fl_s1k;
		always_ff @(posedge clk) begin
			if (en) begin
				fl_s1k <= fl_sk[k];
			end
		end
		assign fl_sk[k+1] = fl_s1k;
	end

	// rounding of the root, clamp and quadrant of the angle
	assign root_end = rr_sk[N];
	assign rem_end  = rv_sk[N];
	assign z_end    = cz_sk[N];

	always_comb begin
		len_pre = root_end[21:0] + {21'd0, (rem_end > root_end)};
		if (fl_sk[N].sat || len_pre > {2'b00, LEN_MAX}) begin
			len_nxt = LEN_MAX;
		end else begin
			len_nxt = len_pre[LEN_W-1:0];
		end

		if (z_end[ZW-1]) begin
			theta = '0;
		end else if (ANG_W'(z_end) > DEG90_Q16) begin
			theta = DEG90_Q16;
		end else begin
			theta = ANG_W'(z_end);
		end
		if (fl_sk[N].ay_zero) begin
			theta = '0;
		end else if (fl_sk[N].ax_zero) begin
			theta = DEG90_Q16;
		end

		if (!fl_sk[N].xneg && (fl_sk[N].yneg || fl_sk[N].ay_zero)) begin
			ang_nxt = theta;
		end else if (fl_sk[N].xneg && fl_sk[N].yneg) begin
			ang_nxt = DEG180_Q16 - theta;
		end else if (fl_sk[N].xneg) begin
			ang_nxt = DEG180_Q16 + theta;
		end else if (fl_sk[N].ax_zero) begin
			ang_nxt = DEG270_Q16;
		end else begin
			ang_nxt = DEG360_Q16 - theta;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_sf <= len_nxt;
			ang_sf <= ang_nxt;
			fl_sf  <= fl_sk[N];
		end
	end

	// round to 1/256 degree, wrap a full turn and zero the word of the zero vector
	always_comb begin
		ang_rnd = 18'((26'(ang_sf) + 26'd128) >> 8);
		if (ang_rnd >= {1'b0, FULL_TURN_Q8}) begin
			ang_fin = ANGLE_W'(ang_rnd - {1'b0, FULL_TURN_Q8});
		end else begin
			ang_fin = ang_rnd[ANGLE_W-1:0];
		end

		if (fl_sf.ax_zero && fl_sf.ay_zero) begin
			res_nxt = '{zero_error: 1'b1, angle_q8: '0, length_q4: '0};
		end else begin
			res_nxt = '{zero_error: 1'b0, angle_q8: ang_fin, length_q4: len_sf};
		end
	end

	// output word and skid word
	assign out_free = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= v_q[NV-1];
			end
		end else if (en && v_q[NV-1]) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_res_q <= skid_v_q ? skid_res_q : res_nxt;
		end else if (en && v_q[NV-1]) begin
			skid_res_q <= res_nxt;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {3'b000, out_res_q.angle_q8, out_res_q.length_q4};
	assign m_tuser  = out_res_q.zero_error;

`ifndef SYNTHESIS
	a_zero_clears_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("zero vector word carries nonzero length or angle");

	a_angle_below_turn: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[36:20] < FULL_TURN_Q8)
		else $error("angle not below a full turn");

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid word held while output word empty");

	a_skid_catches: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !m_tready && v_q[NV-1] && en |=> skid_v_q)
		else $error("finished word dropped during output stall");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output empty");
`endif

endmodule

[tb/vector_magnitude_and_angle_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector_magnitude_and_angle_unit_tb
// self-checking bench for the rectangular to polar unit
// ----------------------------------------------------------------------------
// Streams signed vectors into the unit, first a directed set (axes, extremes,
// diagonals, the zero vector, angles that round up to a full turn), then
// random vectors weighted toward special regions. Each accepted vector is
// converted by a bit-accurate integer square root and CORDIC predictor; each
// output word is compared field by field with the oldest prediction. Both
// sides idle and stall at random, with stretches of full-rate flow.
// ----------------------------------------------------------------------------
module vector_magnitude_and_angle_unit_tb;

	import vma_pkg::*;

	localparam int COORD_W       = COORD_WIDTH_DEF;
	localparam int STAGES        = CORDIC_STAGES_DEF;
	localparam int LATENCY       = 26;
	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_COUNT  = 450;
	localparam int MAX_REPORTS   = 10;

	// atan(2^-i) in 1/65536 degree
	localparam longint ATAN_Q16 [STAGES] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29
	};

	class polar_scoreboard;
		vma_result_t expected_polar[$];
		int          errors;
		int          checked;
		int          vectors;
		int          zero_vectors;
		int          axis_vectors;

		function vma_result_t polar_of(logic [COORD_W-1:0] rx, logic [COORD_W-1:0] ry);
			logic [COORD_W:0]   ax;
			logic [COORD_W:0]   ay;
			logic [63:0]        rad;
			logic [63:0]        root;
			logic [63:0]        bitv;
			logic signed [63:0] a;
			logic signed [63:0] b;
			logic signed [63:0] da;
			logic signed [63:0] db;
			longint             z;
			longint             theta;
			longint             ang;
			vma_result_t        res;
			ax = rx[COORD_W-1] ? ({1'b1, {COORD_W{1'b0}}} - {1'b0, rx}) : {1'b0, rx};
			ay = ry[COORD_W-1] ? ({1'b1, {COORD_W{1'b0}}} - {1'b0, ry}) : {1'b0, ry};
			res = '0;
			if (ax == 0 && ay == 0) begin
				res.zero_error = 1'b1;
				return res;
			end
			// length: rounded integer square root of 256 * (x^2 + y^2)
			rad = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay);
			if (rad >= (64'd1 << 34)) begin
				res.length_q4 = LEN_MAX;
			end else begin
				rad = rad << 8;
				root = 0;
				bitv = 64'd1 << 62;
				while (bitv > rad)
					bitv = bitv >> 2;
				while (bitv != 0) begin
					if (rad >= root + bitv) begin
						rad = rad - (root + bitv);
						root = (root >> 1) + bitv;
					end else begin
						root = root >> 1;
					end
					bitv = bitv >> 2;
				end
				if (rad > root)
					root = root + 1;
				res.length_q4 = (root > 64'(LEN_MAX)) ? LEN_MAX : root[LEN_W-1:0];
			end
			// first-quadrant angle
			if (ay == 0) begin
				theta = 0;
			end else if (ax == 0) begin
				theta = longint'(DEG90_Q16);
			end else begin
				a = 64'(ax) << (CORDIC_TOP - COORD_W);
				b = 64'(ay) << (CORDIC_TOP - COORD_W);
				z = 0;
				for (int i = 0; i < STAGES; i++) begin
					da = b >>> i;
					db = a >>> i;
					if (!b[63]) begin
						a = a + da;
						b = b - db;
						z = z + ATAN_Q16[i];
					end else begin
						a = a - da;
						b = b + db;
						z = z - ATAN_Q16[i];
					end
				end
				if (z < 0)
					z = 0;
				if (z > longint'(DEG90_Q16))
					z = longint'(DEG90_Q16);
				theta = z;
			end
			// quadrant mapping, screen convention
			if (!rx[COORD_W-1] && (ry[COORD_W-1] || ay == 0))
				ang = theta;
			else if (rx[COORD_W-1] && ry[COORD_W-1])
				ang = longint'(DEG180_Q16) - theta;
			else if (rx[COORD_W-1])
				ang = longint'(DEG180_Q16) + theta;
			else if (ax == 0)
				ang = longint'(DEG270_Q16);
			else
				ang = longint'(DEG360_Q16) - theta;
			ang = (ang + 128) >>> 8;
			if (ang >= longint'(FULL_TURN_Q8))
				ang = ang - longint'(FULL_TURN_Q8);
			res.angle_q8 = ang[ANGLE_W-1:0];
			return res;
		endfunction

		function void note_vector(logic [COORD_W-1:0] rx, logic [COORD_W-1:0] ry);
			vectors++;
			if (rx == 0 && ry == 0)
				zero_vectors++;
			else if (rx == 0 || ry == 0)
				axis_vectors++;
			expected_polar.push_back(polar_of(rx, ry));
		endfunction

		function void check_polar(logic [OUT_TDATA_W-1:0] data, logic zerr);
			vma_result_t exp_res;
			logic [LEN_W-1:0]   got_len;
			logic [ANGLE_W-1:0] got_ang;
			got_len = data[LEN_W-1:0];
			got_ang = data[LEN_W+ANGLE_W-1:LEN_W];
			if (expected_polar.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("ERROR: unexpected word len=%0d ang=%0d zero=%0b",
						got_len, got_ang, zerr);
				return;
			end
			exp_res = expected_polar.pop_front();
			checked++;
			if (got_len !== exp_res.length_q4 || got_ang !== exp_res.angle_q8 ||
				zerr !== exp_res.zero_error) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("ERROR: word %0d exp len=%0d ang=%0d zero=%0b got len=%0d ang=%0d zero=%0b",
						checked, exp_res.length_q4, exp_res.angle_q8, exp_res.zero_error,
						got_len, got_ang, zerr);
			end
		endfunction

		function int pending();
			return expected_polar.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [2*COORD_W-1:0]   s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;

	polar_scoreboard sb = new();
	bit              steady_flow = 1'b0;
	int              idle_cycles = 0;

	vector_magnitude_and_angle_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady_flow || r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// returns in the time step of acceptance, valid still high
	task automatic send_vector(input logic [COORD_W-1:0] vx, input logic [COORD_W-1:0] vy);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {vy, vx};
		do @(posedge clk); while (!s_tready);
		sb.note_vector(vx, vy);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// receiver with random stalls
	initial begin
		int run;
		int stall;
		@(posedge arst_n);
		forever begin
			if (steady_flow) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				run = $urandom_range(1, 20);
				m_tready <= 1'b1;
				repeat (run) @(posedge clk);
				stall = pick_gap();
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_polar(m_tdata, m_tuser);
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("ERROR: no progress for %0d cycles, %0d words pending",
				STALL_LIMIT, sb.pending());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic signed [COORD_W-1:0] dir_x [22];
		logic signed [COORD_W-1:0] dir_y [22];
		logic [COORD_W-1:0]        vx;
		logic [COORD_W-1:0]        vy;
		int                        kind;

		// zero, axes, extremes, diagonals, near-full-turn rounding
		dir_x = '{0, 32767, -32768, 0, 0, 1, 0, -1, 0, -32768, 32767,
			-32768, 32767, 1, -1, 1, -1, 3, -3, 32767, 32767, -32768};
		dir_y = '{0, 0, 0, -32768, 32767, 0, 1, 0, -1, -32768, 32767,
			32767, -32768, 1, -1, -1, 1, 4, 4, 1, -1, 1};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 22; i++)
			send_vector(dir_x[i], dir_y[i]);
		drain_results();

		for (int n = 0; n < RANDOM_COUNT; n++) begin
			if (n % 50 == 0)
				steady_flow = ($urandom_range(0, 3) == 0);
			if (n == RANDOM_COUNT / 2) begin
				steady_flow = 1'b0;
				drain_results();
			end
			kind = $urandom_range(0, 99);
			vx = COORD_W'($urandom());
			vy = COORD_W'($urandom());
			if (kind < 15) begin
				vx = COORD_W'($urandom_range(0, 16) - 8);
				vy = COORD_W'($urandom_range(0, 16) - 8);
			end else if (kind < 25) begin
				if ($urandom_range(0, 1))
					vx = '0;
				else
					vy = '0;
			end else if (kind < 30) begin
				vx = '0;
				vy = '0;
			end else if (kind < 40) begin
				// large components near the edges and diagonals
				vx = $urandom_range(0, 1) ? COORD_W'(16'h8000 + $urandom_range(0, 3)) :
					COORD_W'(16'h7FFF - $urandom_range(0, 3));
				vy = $urandom_range(0, 1) ? vx : $urandom_range(0, 1) ? -vx : 16'(vx ^ 16'h0001);
			end else if (kind < 45) begin
				// nearly horizontal, angle close to 0 or 180
				vy = COORD_W'($urandom_range(0, 4) - 2);
			end
			send_vector(vx, vy);
		end
		steady_flow = 1'b0;
		s_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (3 * LATENCY) @(posedge clk);

		$display("covered %0d vectors (%0d zero, %0d on an axis), %0d words checked",
			sb.vectors, sb.zero_vectors, sb.axis_vectors, sb.checked);
		$display("random stalls on both sides, full-rate bursts, %0d mismatches", sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[sim.f]
sv/vma_pkg.sv
sv/vma_isqrt_stage.sv
sv/vma_cordic_stage.sv
sv/vector_magnitude_and_angle_unit.sv
tb/vector_magnitude_and_angle_unit_tb.sv
